### design/pit_pkg.sv
`timescale 1ns / 1ps
package pit_pkg;

  // sign summary of one exact product term
  typedef struct packed {
    logic neg;
    logic zero;
  } sgn_t;

  localparam int unsigned OUT_TDATA_BITS = 8;

endpackage

### design/pit_prod2.sv
`timescale 1ns / 1ps
// 2D cross (ux*vy - uy*vx) or dot (ux*vx + uy*vy) product, sign only
module pit_prod2 #(
  parameter int unsigned W      = 17,
  parameter bit          IS_DOT = 1'b0
) (
  input  logic signed [W-1:0] ux,
  input  logic signed [W-1:0] uy,
  input  logic signed [W-1:0] vx,
  input  logic signed [W-1:0] vy,
  output pit_pkg::sgn_t       sgn
);

  localparam int unsigned PW = 2 * W;
  localparam int unsigned RW = PW + 1;

  logic signed [PW-1:0] prod0;
  logic signed [PW-1:0] prod1;
  logic signed [RW-1:0] res;

  assign prod0 = PW'(ux) * PW'(IS_DOT ? vx : vy);
  assign prod1 = PW'(uy) * PW'(IS_DOT ? vy : vx);
  assign res   = IS_DOT ? (RW'(prod0) + RW'(prod1)) : (RW'(prod0) - RW'(prod1));

  assign sgn.neg  = res[RW-1];
  assign sgn.zero = (res == '0);

endmodule

### design/point_in_triangle_test.sv
`timescale 1ns / 1ps
// Point-in-triangle test: takes corners A, B, C and point P as signed
// COORD_BITS-bit coordinates and returns 1 when P lies inside or on the
// triangle, using exact edge cross-product signs (a degenerate triangle
// is handled with collinearity and dot-product checks). One transfer is
// accepted every cycle unless output backpressure stalls; an accepted
// transfer passes the input register, then the result register, before
// out_tvalid rises. The multiply and sign logic between those two
// registers sets the clock rate. Output backpressure stalls both stages;
// a result waiting in the output register does not block acceptance
// while the input stage is free.
module point_in_triangle_test #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // a_x, a_y, b_x, b_y, c_x, c_y, p_x, p_y (COORD_BITS each)
  input  logic [8*COORD_BITS-1:0]                in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // inside_res, zero fill
  output logic [pit_pkg::OUT_TDATA_BITS-1:0]     out_tdata
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned DW = CB + 1;

  logic                  s1_valid_r;
  logic [8*CB-1:0]       s1_data_r;
  logic                  out_valid_r;
  logic                  inside_r;
  logic                  inside_nxt;
  logic                  out_adv;
  logic                  s1_adv;

  assign out_adv   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || out_adv;
  assign s1_adv    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_data_r <= in_tdata;
    end
    if (out_adv) begin
      inside_r <= inside_nxt;
    end
  end

  logic signed [CB-1:0] ax, ay, bx, by, cx, cy, px, py;
  assign ax = s1_data_r[0*CB +: CB];
  assign ay = s1_data_r[1*CB +: CB];
  assign bx = s1_data_r[2*CB +: CB];
  assign by = s1_data_r[3*CB +: CB];
  assign cx = s1_data_r[4*CB +: CB];
  assign cy = s1_data_r[5*CB +: CB];
  assign px = s1_data_r[6*CB +: CB];
  assign py = s1_data_r[7*CB +: CB];

  // edge and point differences, one bit wider than the coordinates
  logic signed [DW-1:0] ba_x, ba_y, ca_x, ca_y, pa_x, pa_y;
  logic signed [DW-1:0] cb_x, cb_y, ab_x, ab_y, pb_x, pb_y;
  logic signed [DW-1:0] ac_x, ac_y, bc_x, bc_y, pc_x, pc_y;
  logic signed [DW-1:0] ap_x, ap_y, bp_x, bp_y, cp_x, cp_y;

  assign ba_x = DW'(bx) - DW'(ax);
  assign ba_y = DW'(by) - DW'(ay);
  assign ca_x = DW'(cx) - DW'(ax);
  assign ca_y = DW'(cy) - DW'(ay);
  assign pa_x = DW'(px) - DW'(ax);
  assign pa_y = DW'(py) - DW'(ay);
  assign cb_x = DW'(cx) - DW'(bx);
  assign cb_y = DW'(cy) - DW'(by);
  assign ab_x = DW'(ax) - DW'(bx);
  assign ab_y = DW'(ay) - DW'(by);
  assign pb_x = DW'(px) - DW'(bx);
  assign pb_y = DW'(py) - DW'(by);
  assign ac_x = DW'(ax) - DW'(cx);
  assign ac_y = DW'(ay) - DW'(cy);
  assign bc_x = DW'(bx) - DW'(cx);
  assign bc_y = DW'(by) - DW'(cy);
  assign pc_x = DW'(px) - DW'(cx);
  assign pc_y = DW'(py) - DW'(cy);
  assign ap_x = DW'(ax) - DW'(px);
  assign ap_y = DW'(ay) - DW'(py);
  assign bp_x = DW'(bx) - DW'(px);
  assign bp_y = DW'(by) - DW'(py);
  assign cp_x = DW'(cx) - DW'(px);
  assign cp_y = DW'(cy) - DW'(py);

  pit_pkg::sgn_t p_ab, c_ab, p_bc, a_bc, p_ca, b_ca, s_ab, s_bc, s_ca;

  pit_prod2 #(.W(DW), .IS_DOT(1'b0)) u_p_ab (
    .ux(pa_x), .uy(pa_y), .vx(ba_x), .vy(ba_y), .sgn(p_ab));
  pit_prod2 #(.W(DW), .IS_DOT(1'b0)) u_c_ab (
    .ux(ca_x), .uy(ca_y), .vx(ba_x), .vy(ba_y), .sgn(c_ab));
  pit_prod2 #(.W(DW), .IS_DOT(1'b0)) u_p_bc (
    .ux(pb_x), .uy(pb_y), .vx(cb_x), .vy(cb_y), .sgn(p_bc));
  pit_prod2 #(.W(DW), .IS_DOT(1'b0)) u_a_bc (
    .ux(ab_x), .uy(ab_y), .vx(cb_x), .vy(cb_y), .sgn(a_bc));
  pit_prod2 #(.W(DW), .IS_DOT(1'b0)) u_p_ca (
    .ux(pc_x), .uy(pc_y), .vx(ac_x), .vy(ac_y), .sgn(p_ca));
  pit_prod2 #(.W(DW), .IS_DOT(1'b0)) u_b_ca (
    .ux(bc_x), .uy(bc_y), .vx(ac_x), .vy(ac_y), .sgn(b_ca));
  pit_prod2 #(.W(DW), .IS_DOT(1'b1)) u_s_ab (
    .ux(ap_x), .uy(ap_y), .vx(bp_x), .vy(bp_y), .sgn(s_ab));
  pit_prod2 #(.W(DW), .IS_DOT(1'b1)) u_s_bc (
    .ux(bp_x), .uy(bp_y), .vx(cp_x), .vy(cp_y), .sgn(s_bc));
  pit_prod2 #(.W(DW), .IS_DOT(1'b1)) u_s_ca (
    .ux(cp_x), .uy(cp_y), .vx(ap_x), .vy(ap_y), .sgn(s_ca));

  logic distinct;
  logic ab_ok;
  logic degen_out;

  assign distinct = (ap_x != '0 || ap_y != '0) &&
                    (bp_x != '0 || bp_y != '0) &&
                    (cp_x != '0 || cp_y != '0);

  assign ab_ok = p_ab.zero || (c_ab.neg == p_ab.neg);

  // degenerate triangle: off-line P, or collinear P outside all corners
  assign degen_out = c_ab.zero &&
                     (!p_ab.zero ||
                      (distinct && (s_ab.neg == s_bc.neg) && (s_ab.neg == s_ca.neg)));

  assign inside_nxt = ab_ok && !degen_out &&
                      (p_bc.zero || (a_bc.neg == p_bc.neg)) &&
                      (p_ca.zero || (b_ca.neg == p_ca.neg));

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(pit_pkg::OUT_TDATA_BITS-1){1'b0}}, inside_r};

`ifndef ASSERT_OFF
  a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_adv |=> out_tvalid)
    else $error("result stage did not load a pending item");

  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output drains");

  a_degen_off: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_adv && c_ab.zero && !p_ab.zero |=> !out_tdata[0])
    else $error("off-line point reported inside a degenerate triangle");
`endif

endmodule
